// ----- rtl/crup_pkg.sv -----
// shared types, register indexes, status codes and constants for the
// command ring rectangle update producer; no dependencies
package crup_pkg;

    localparam int unsigned RING_BYTES_DEF    = 262144;
    localparam logic [31:0] UPDATE_OPCODE_DEF = 32'd1;

    localparam int unsigned PTR_W       = 19;
    localparam int unsigned OFF_W       = 18;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned WORD_SEL_W  = 3;

    localparam logic [PTR_W-1:0] RING_MIN_RESET = 19'd16;
    localparam logic [PTR_W-1:0] RING_MAX_RESET = 19'd262144;

    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned CMD_BYTES  = 5 * WORD_BYTES;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_READY  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RING_MIN      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RING_MAX      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

    localparam logic [WORD_SEL_W-1:0] WORD_OPCODE = 3'd0;
    localparam logic [WORD_SEL_W-1:0] WORD_X      = 3'd1;
    localparam logic [WORD_SEL_W-1:0] WORD_Y      = 3'd2;
    localparam logic [WORD_SEL_W-1:0] WORD_WIDTH  = 3'd3;
    localparam logic [WORD_SEL_W-1:0] WORD_HEIGHT = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_NOT_READY = 3'd2;
    localparam logic [2:0] ST_BOUNDS    = 3'd3;
    localparam logic [2:0] ST_BAD_PTR   = 3'd4;
    localparam logic [2:0] ST_NO_SPACE  = 3'd5;

    typedef struct packed {
        logic        kind;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [17:0] consumer_stop;
    } req_t;

    typedef struct packed {
        logic        word_valid;
        logic [17:0] word_offset;
        logic [31:0] word_data;
        logic [17:0] next_pointer;
        logic [2:0]  status;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic                  load;
        logic                  first;
        logic                  step;
        logic [WORD_SEL_W-1:0] word_sel;
    } ctl_t;

    typedef struct packed {
        logic       is_stop;
        logic [2:0] status;
    } stat_t;

endpackage

// ----- rtl/command_ring_rect_update_producer.sv -----
// update request: the idle state takes start, the check state forms the
// opcode word, then the emit state forms the four further ring words;
// the five ring words come out on consecutive cycles
// rejected request or stop report: one result, registered from the check state
// busy drops as the final result shows, so a new start is taken that cycle
// results cannot be stalled; cfg_ready is always high
// async reset: device not ready, ring 16..262144, both pointers at 16
module command_ring_rect_update_producer #(
    parameter int unsigned RING_BYTES    = crup_pkg::RING_BYTES_DEF,
    parameter logic [31:0] UPDATE_OPCODE = crup_pkg::UPDATE_OPCODE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  crup_pkg::req_t                   req,
    output logic                             strobe,
    output crup_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crup_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crup_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import crup_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    crup_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    crup_datapath #(
        .RING_BYTES    (RING_BYTES),
        .UPDATE_OPCODE (UPDATE_OPCODE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat),
        .strobe    (strobe),
        .rsp       (rsp)
    );

endmodule

// ----- rtl/crup_ctrl.sv -----
// controller state machine: accept, check, then step through the ring words
// depends on crup_pkg
module crup_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  crup_pkg::stat_t stat,
    output crup_pkg::ctl_t  ctl
);
    import crup_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        CHECK,
        EMIT
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [WORD_SEL_W-1:0] sel_reg;
    logic [WORD_SEL_W-1:0] sel_next;

    assign busy = (state_reg != IDLE);

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        ctl.load     = 1'b0;
        ctl.first    = 1'b0;
        ctl.step     = 1'b0;
        ctl.word_sel = WORD_OPCODE;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = CHECK;
                end
            end
            CHECK:
            begin
                ctl.first = 1'b1;
                if (stat.is_stop || (stat.status != ST_OK))
                begin
                    state_next = IDLE;
                end
                else
                begin
                    state_next = EMIT;
                    sel_next   = WORD_X;
                end
            end
            EMIT:
            begin
                ctl.step     = 1'b1;
                ctl.word_sel = sel_reg;
                sel_next     = sel_reg + WORD_SEL_W'(1);
                if (sel_reg == WORD_HEIGHT)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            sel_reg   <= WORD_OPCODE;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ----- rtl/crup_datapath.sv -----
// datapath: configuration registers, ring pointers, request checks and
// ring word generation; depends on crup_pkg
module crup_datapath #(
    parameter int unsigned RING_BYTES    = crup_pkg::RING_BYTES_DEF,
    parameter logic [31:0] UPDATE_OPCODE = crup_pkg::UPDATE_OPCODE_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  crup_pkg::req_t                       req,
    input  logic                                 cfg_write,
    input  logic [crup_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [crup_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  crup_pkg::ctl_t                       ctl,
    output crup_pkg::stat_t                      stat,
    output logic                                 strobe,
    output crup_pkg::rsp_t                       rsp
);
    import crup_pkg::*;

    logic             device_ready_reg;
    logic [PTR_W-1:0] ring_min_reg;
    logic [PTR_W-1:0] ring_max_reg;
    logic [15:0]      screen_width_reg;
    logic [15:0]      screen_height_reg;
    logic [PTR_W-1:0] next_ptr_reg;
    logic [PTR_W-1:0] stop_ptr_reg;
    logic [PTR_W-1:0] off_reg;
    req_t             item_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             strobe_reg;

    logic               out_of_bounds;
    logic               bad_ptr;
    logic signed [21:0] free_bytes;
    logic [2:0]         chk_status;
    logic [PTR_W-1:0]   cur_off;
    logic [PTR_W:0]     off_inc;
    logic [PTR_W-1:0]   off_wrap;
    logic [31:0]        word;
    logic               emit;
    logic               reply;
    logic               is_last;

    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

    // request checks
    always_comb
    begin
        out_of_bounds = (item_reg.rect_x > screen_width_reg)
            || (item_reg.rect_y > screen_height_reg)
            || (({1'b0, item_reg.rect_width} + {1'b0, item_reg.rect_x})
                > {1'b0, screen_width_reg})
            || (({1'b0, item_reg.rect_height} + {1'b0, item_reg.rect_y})
                > {1'b0, screen_height_reg});

        bad_ptr = (ring_min_reg >= ring_max_reg)
            || (32'(ring_max_reg) > 32'(RING_BYTES))
            || (next_ptr_reg < ring_min_reg) || (next_ptr_reg >= ring_max_reg)
            || (stop_ptr_reg < ring_min_reg) || (stop_ptr_reg >= ring_max_reg);

        if (next_ptr_reg >= stop_ptr_reg)
        begin
            free_bytes = 22'(signed'({3'b000, ring_max_reg}))
                - 22'(signed'({3'b000, next_ptr_reg}))
                + 22'(signed'({3'b000, stop_ptr_reg}))
                - 22'(signed'({3'b000, ring_min_reg}))
                - 22'(WORD_BYTES);
        end
        else
        begin
            free_bytes = 22'(signed'({3'b000, stop_ptr_reg}))
                - 22'(signed'({3'b000, next_ptr_reg}))
                - 22'(WORD_BYTES);
        end

        priority if (!device_ready_reg)
            chk_status = ST_NOT_READY;
        else if ((item_reg.rect_width == 16'd0) || (item_reg.rect_height == 16'd0))
            chk_status = ST_EMPTY;
        else if (out_of_bounds)
            chk_status = ST_BOUNDS;
        else if (bad_ptr)
            chk_status = ST_BAD_PTR;
        else if (free_bytes < signed'(22'(CMD_BYTES)))
            chk_status = ST_NO_SPACE;
        else
            chk_status = ST_OK;

        stat.is_stop = item_reg.kind;
        stat.status  = chk_status;
    end

    // ring word generation with wrap from ring_max to ring_min
    always_comb
    begin
        cur_off  = ctl.first ? next_ptr_reg : off_reg;
        off_inc  = {1'b0, cur_off} + (PTR_W + 1)'(WORD_BYTES);
        off_wrap = (off_inc >= {1'b0, ring_max_reg}) ? ring_min_reg : off_inc[PTR_W-1:0];
        is_last  = (ctl.word_sel == WORD_HEIGHT);
        reply    = ctl.first && (item_reg.kind || (chk_status != ST_OK));
        emit     = (ctl.first && !reply) || ctl.step;

        unique case (ctl.word_sel)
            WORD_OPCODE: word = UPDATE_OPCODE;
            WORD_X:      word = {16'd0, item_reg.rect_x};
            WORD_Y:      word = {16'd0, item_reg.rect_y};
            WORD_WIDTH:  word = {16'd0, item_reg.rect_width};
            WORD_HEIGHT: word = {16'd0, item_reg.rect_height};
            default:     word = 32'd0;
        endcase

        if (reply)
        begin
            rsp_next.word_valid   = 1'b0;
            rsp_next.word_offset  = '0;
            rsp_next.word_data    = '0;
            rsp_next.next_pointer = next_ptr_reg[OFF_W-1:0];
            rsp_next.status       = item_reg.kind ? ST_OK : chk_status;
            rsp_next.last         = 1'b1;
        end
        else
        begin
            rsp_next.word_valid   = 1'b1;
            rsp_next.word_offset  = {cur_off[OFF_W-1:2], 2'b00};
            rsp_next.word_data    = word;
            rsp_next.next_pointer = is_last ? off_wrap[OFF_W-1:0] : next_ptr_reg[OFF_W-1:0];
            rsp_next.status       = ST_OK;
            rsp_next.last         = is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= req;
        end
        if (emit)
        begin
            off_reg <= off_wrap;
        end
        if (ctl.first || ctl.step)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_ready_reg  <= 1'b0;
            ring_min_reg      <= RING_MIN_RESET;
            ring_max_reg      <= RING_MAX_RESET;
            screen_width_reg  <= 16'd0;
            screen_height_reg <= 16'd0;
            next_ptr_reg      <= RING_MIN_RESET;
            stop_ptr_reg      <= RING_MIN_RESET;
            strobe_reg        <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.first || ctl.step;
            if (ctl.first && item_reg.kind)
            begin
                stop_ptr_reg <= {1'b0, item_reg.consumer_stop};
            end
            if (emit && is_last)
            begin
                next_ptr_reg <= off_wrap;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_DEVICE_READY:  device_ready_reg  <= cfg_data[0];
                    REG_RING_MIN:
                    begin
                        ring_min_reg <= cfg_data[PTR_W-1:0];
                        next_ptr_reg <= cfg_data[PTR_W-1:0];
                        stop_ptr_reg <= cfg_data[PTR_W-1:0];
                    end
                    REG_RING_MAX:      ring_max_reg      <= cfg_data[PTR_W-1:0];
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[15:0];
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking bench for command_ring_rect_update_producer: directed table, then
// randomized configuration phases, each ring write checked against an in-bench predictor
// depends on crup_pkg and the producer rtl only
module tb_top;
    import crup_pkg::*;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_STOP   = 1'b1;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 25;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_t;

    typedef struct {
        row_t                   what;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  value;
        req_t                   item;
        bit                     known;
        logic [2:0]             st;
        logic [17:0]            nxt;
    } dir_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    req_t                   req       = '0;
    logic                   strobe;
    rsp_t                   rsp;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic        ready_cfg = 1'b0;
    logic [18:0] ring_lo   = RING_MIN_RESET;
    logic [18:0] ring_hi   = RING_MAX_RESET;
    logic [15:0] scr_w     = '0;
    logic [15:0] scr_h     = '0;
    logic [18:0] next_off  = RING_MIN_RESET;
    logic [18:0] stop_off  = RING_MIN_RESET;

    rsp_t     expected_writes[$];
    dir_row_t dir_rows[$];
    int       mismatches = 0;

    command_ring_rect_update_producer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .strobe    (strobe),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic produce_commands(input req_t r);
        logic [2:0]  st;
        logic [31:0] words [5];
        logic [31:0] off;
        logic [18:0] old;
        longint      room;
        rsp_t        e;
        e = '0;
        if (r.kind == KIND_STOP)
        begin
            stop_off = {1'b0, r.consumer_stop};
            e.next_pointer = next_off[17:0];
            e.status = ST_OK;
            e.last = 1'b1;
            expected_writes.push_back(e);
            return;
        end
        if (next_off >= stop_off)
            room = longint'(ring_hi) - longint'(next_off) + longint'(stop_off)
                   - longint'(ring_lo) - longint'(WORD_BYTES);
        else
            room = longint'(stop_off) - longint'(next_off) - longint'(WORD_BYTES);
        if (!ready_cfg)
            st = ST_NOT_READY;
        else if (r.rect_width == 0 || r.rect_height == 0)
            st = ST_EMPTY;
        else if (r.rect_x > scr_w || r.rect_y > scr_h
                 || int'(r.rect_width) > int'(scr_w) - int'(r.rect_x)
                 || int'(r.rect_height) > int'(scr_h) - int'(r.rect_y))
            st = ST_BOUNDS;
        else if (ring_lo >= ring_hi || ring_hi > RING_BYTES_DEF
                 || next_off < ring_lo || next_off >= ring_hi
                 || stop_off < ring_lo || stop_off >= ring_hi)
            st = ST_BAD_PTR;
        else if (room < longint'(CMD_BYTES))
            st = ST_NO_SPACE;
        else
            st = ST_OK;
        if (st != ST_OK)
        begin
            e.next_pointer = next_off[17:0];
            e.status = st;
            e.last = 1'b1;
            expected_writes.push_back(e);
            return;
        end
        words[WORD_OPCODE] = UPDATE_OPCODE_DEF;
        words[WORD_X]      = {16'd0, r.rect_x};
        words[WORD_Y]      = {16'd0, r.rect_y};
        words[WORD_WIDTH]  = {16'd0, r.rect_width};
        words[WORD_HEIGHT] = {16'd0, r.rect_height};
        off = {13'd0, next_off};
        old = next_off;
        for (int k = 0; k < 5; k++)
        begin
            e = '0;
            e.word_valid = 1'b1;
            e.word_offset = off[17:0] & ~18'd3;
            e.word_data = words[k];
            e.status = ST_OK;
            off = off + WORD_BYTES;
            if (off >= ring_hi)
                off = {13'd0, ring_lo};
            if (k == 4)
            begin
                next_off = off[18:0];
                e.next_pointer = next_off[17:0];
                e.last = 1'b1;
            end
            else
                e.next_pointer = old[17:0];
            expected_writes.push_back(e);
        end
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_writes
        rsp_t want;
        if (rst_n && strobe)
        begin
            if (expected_writes.size() == 0)
            begin
                $error("result with nothing pending: offset %0d, status %0d",
                       rsp.word_offset, rsp.status);
                mismatches++;
            end
            else
            begin
                want = expected_writes.pop_front();
                compare_field("word_valid", 64'(want.word_valid), 64'(rsp.word_valid));
                compare_field("word_offset", 64'(want.word_offset), 64'(rsp.word_offset));
                compare_field("word_data", 64'(want.word_data), 64'(rsp.word_data));
                compare_field("next_pointer", 64'(want.next_pointer),
                              64'(rsp.next_pointer));
                compare_field("status", 64'(want.status), 64'(rsp.status));
                compare_field("last", 64'(want.last), 64'(rsp.last));
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_item(input req_t r);
        int gap;
        gap = sender_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        produce_commands(r);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] v);
        int gap;
        gap = sender_gap();
        if (gap != 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_DEVICE_READY:  ready_cfg = v[0];
            REG_RING_MIN:
            begin
                ring_lo = v[18:0];
                next_off = v[18:0];
                stop_off = v[18:0];
            end
            REG_RING_MAX:      ring_hi = v[18:0];
            REG_SCREEN_WIDTH:  scr_w = v[15:0];
            REG_SCREEN_HEIGHT: scr_h = v[15:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // sender idle until every pending ring write has come out
    task automatic wait_drain();
        start <= 1'b0;
        while (expected_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic row_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] v);
        dir_row_t d;
        d.what = ROW_CFG;
        d.idx = idx;
        d.value = v;
        d.item = '0;
        d.known = 1'b0;
        d.st = ST_OK;
        d.nxt = '0;
        dir_rows.push_back(d);
    endtask

    task automatic row_item(input logic kind, input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [17:0] stop, input bit known,
                            input logic [2:0] st, input logic [17:0] nxt);
        dir_row_t d;
        d.what = ROW_ITEM;
        d.idx = '0;
        d.value = '0;
        d.item.kind = kind;
        d.item.rect_x = x;
        d.item.rect_y = y;
        d.item.rect_width = w;
        d.item.rect_height = h;
        d.item.consumer_stop = stop;
        d.known = known;
        d.st = st;
        d.nxt = nxt;
        dir_rows.push_back(d);
    endtask

    function automatic logic [15:0] pick_screen();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'hFFFF;
        if (r == 1)
            return 16'($urandom_range(1, 8));
        return 16'($urandom_range(1, 65535));
    endfunction

    task automatic setup_phase(input int p);
        logic [18:0] lo;
        logic [18:0] hi;
        int          opt;
        opt = (p < 5) ? p : $urandom_range(0, 3);
        case (opt)
            0:
            begin
                lo = 19'(4 * $urandom_range(0, 16));
                hi = lo + 19'(4 * $urandom_range(5, 30));
            end
            1:
            begin
                lo = 19'($urandom_range(0, 64));
                hi = lo + 19'($urandom_range(20, 120));
            end
            2:
            begin
                hi = 19'(RING_BYTES_DEF);
                lo = hi - 19'(4 * $urandom_range(6, 40) + $urandom_range(0, 3));
            end
            3:
            begin
                lo = ($urandom_range(0, 1) == 0) ? 19'd0 : RING_MIN_RESET;
                hi = 19'(RING_BYTES_DEF);
            end
            default:
            begin
                lo = 19'($urandom);
                hi = 19'($urandom);
            end
        endcase
        wait_drain();
        cfg_write(REG_RING_MAX, {13'd0, hi});
        cfg_write(REG_RING_MIN, {13'd0, lo});
        cfg_write(REG_SCREEN_WIDTH, {16'($urandom), pick_screen()});
        cfg_write(REG_SCREEN_HEIGHT, {16'($urandom), pick_screen()});
        cfg_write(REG_DEVICE_READY, {31'($urandom), 1'($urandom_range(0, 7) != 0)});
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_INDEX_W'($urandom_range(REG_SCREEN_HEIGHT + 1, {CFG_INDEX_W{1'b1}})),
                      $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t random_request();
        req_t r;
        int   pick;
        r = '0;
        r.rect_x = 16'($urandom);
        r.rect_y = 16'($urandom);
        r.rect_width = 16'($urandom);
        r.rect_height = 16'($urandom);
        r.consumer_stop = 18'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            r.kind = KIND_STOP;
            pick = $urandom_range(0, 99);
            // consumer catches up, lags somewhere inside the ring, or reports garbage
            if (pick < 65 || (pick < 85 && !(ring_lo < ring_hi && ring_hi <= RING_BYTES_DEF)))
                r.consumer_stop = next_off[17:0];
            else if (pick < 85)
                r.consumer_stop = 18'($urandom_range(ring_lo, ring_hi - 1));
        end
        else if (pick < 85 && scr_w != 0 && scr_h != 0)
        begin
            r.kind = KIND_UPDATE;
            r.rect_width = 16'($urandom_range(1, scr_w));
            r.rect_x = 16'($urandom_range(0, scr_w - r.rect_width));
            r.rect_height = 16'($urandom_range(1, scr_h));
            r.rect_y = 16'($urandom_range(0, scr_h - r.rect_height));
        end
        else
        begin
            r.kind = KIND_UPDATE;
            pick = $urandom_range(0, 5);
            if (pick == 0)
                r.rect_width = '0;
            else if (pick == 1)
                r.rect_height = '0;
        end
        return r;
    endfunction

    initial
    begin : stimulus
        dir_row_t d;
        bit       in_cfg;
        rsp_t     typed;
        in_cfg = 1'b0;

        row_item(KIND_UPDATE, 0, 0, 1, 1, 0, 1, ST_NOT_READY, 16);
        row_item(KIND_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF,
                 1, ST_NOT_READY, 16);
        row_item(KIND_STOP, 0, 0, 0, 0, 16, 1, ST_OK, 16);
        row_cfg(REG_DEVICE_READY, 1);
        row_item(KIND_UPDATE, 0, 0, 0, 5, 0, 1, ST_EMPTY, 16);
        row_item(KIND_UPDATE, 0, 0, 5, 0, 0, 1, ST_EMPTY, 16);
        row_item(KIND_UPDATE, 0, 0, 1, 1, 0, 1, ST_BOUNDS, 16);
        row_cfg(REG_SCREEN_WIDTH, 16'hFFFF);
        row_cfg(REG_SCREEN_HEIGHT, 16'hFFFF);
        row_item(KIND_UPDATE, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, ST_OK, 0);
        row_item(KIND_UPDATE, 16'hFFFF, 16'hFFFF, 1, 1, 0, 1, ST_BOUNDS, 36);
        row_item(KIND_UPDATE, 16'hFFFE, 1, 1, 16'hFFFE, 0, 0, ST_OK, 0);
        row_cfg(REG_RING_MAX, 36);
        row_item(KIND_UPDATE, 1, 1, 2, 2, 0, 1, ST_BAD_PTR, 56);
        row_cfg(REG_RING_MIN, 16);
        row_item(KIND_UPDATE, 1, 1, 2, 2, 0, 1, ST_NO_SPACE, 16);
        row_cfg(REG_RING_MAX, 40);
        row_item(KIND_UPDATE, 10, 20, 30, 40, 0, 0, ST_OK, 0);
        row_item(KIND_UPDATE, 1, 1, 1, 1, 0, 1, ST_NO_SPACE, 36);
        row_item(KIND_STOP, 0, 0, 0, 0, 36, 1, ST_OK, 36);
        row_item(KIND_UPDATE, 100, 200, 300, 400, 0, 0, ST_OK, 0);
        // misaligned ring bounds
        row_cfg(REG_RING_MIN, 17);
        row_cfg(REG_RING_MAX, 42);
        row_item(KIND_UPDATE, 5, 6, 7, 8, 0, 0, ST_OK, 0);
        row_item(KIND_STOP, 0, 0, 0, 0, 37, 0, ST_OK, 0);
        row_item(KIND_UPDATE, 9, 10, 11, 12, 0, 0, ST_OK, 0);
        row_item(KIND_STOP, 0, 0, 0, 0, 3, 0, ST_OK, 0);
        row_item(KIND_UPDATE, 1, 1, 1, 1, 0, 1, ST_BAD_PTR, 29);
        row_item(KIND_STOP, 16'h1234, 16'hFFFF, 16'h8000, 16'h00FF, 18'h3FFFF, 0, ST_OK, 0);
        row_item(KIND_UPDATE, 1, 1, 1, 1, 0, 1, ST_BAD_PTR, 29);
        row_cfg(REG_RING_MIN, 42);
        row_item(KIND_UPDATE, 1, 1, 1, 1, 0, 1, ST_BAD_PTR, 42);
        row_cfg(REG_RING_MIN, 16);
        row_cfg(REG_RING_MAX, 262148);
        row_item(KIND_UPDATE, 1, 1, 1, 1, 0, 1, ST_BAD_PTR, 16);
        row_cfg(REG_RING_MAX, RING_BYTES_DEF);
        row_cfg(REG_RING_MIN, 0);
        row_cfg(REG_SCREEN_HEIGHT + 3'd1, 32'hFFFF_FFFF);
        row_cfg(REG_DEVICE_READY, 32'hFFFF_FFFF);
        row_cfg(REG_SCREEN_WIDTH, 32'hABCD_FFFF);
        row_item(KIND_UPDATE, 0, 0, 1, 1, 0, 0, ST_OK, 0);
        // stop just ahead of next gives negative free space
        row_item(KIND_STOP, 0, 0, 0, 0, 22, 0, ST_OK, 0);
        row_item(KIND_UPDATE, 0, 0, 1, 1, 0, 1, ST_NO_SPACE, 20);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            d = dir_rows[i];
            if (d.what == ROW_CFG)
            begin
                if (!in_cfg)
                begin
                    wait_drain();
                    in_cfg = 1'b1;
                end
                cfg_write(d.idx, d.value);
            end
            else
            begin
                if (in_cfg)
                begin
                    cfg_valid <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_item(d.item);
                if (d.known)
                begin
                    void'(expected_writes.pop_back());
                    typed = '0;
                    typed.next_pointer = d.nxt;
                    typed.status = d.st;
                    typed.last = 1'b1;
                    expected_writes.push_back(typed);
                end
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            setup_phase(p);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_drain();
                send_item(random_request());
            end
        end

        wait_drain();
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/crup_pkg.sv
rtl/crup_ctrl.sv
rtl/crup_datapath.sv
rtl/command_ring_rect_update_producer.sv
tb/tb_top.sv
